// ===== rtl/tdpt_pkg.sv =====
`default_nettype none

package tdpt_pkg;

   // Default operand width of the number under test
   localparam int DEF_DATA_WIDTH = 32;

   // Width of the response data bus (one byte holds the prime flag)
   localparam int RSP_DATA_W = 8;

   // Status from the remainder unit back to the sequencer
   typedef struct packed {
      logic done;      // one-cycle pulse when the remainder is final
      logic rem_zero;  // remainder is zero, valid with done
   } div_sts_type;

endpackage

`default_nettype wire

// ===== rtl/tdpt_divider.sv =====
`default_nettype none

module tdpt_divider #(
   parameter int DATA_WIDTH = tdpt_pkg::DEF_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_WIDTH-1:0]   dividend,
   input  logic [DATA_WIDTH-1:0]   divisor,
   output tdpt_pkg::div_sts_type   sts
);
   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         if (diff[DATA_WIDTH] == 1'b0) begin
            rem_in = diff[DATA_WIDTH-1:0];
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/trial_division_primality_test.sv =====
// Flow: numbers of 1 or less, and negative values, are answered straight from idle; 2 and 3
//   after the first bound check. Otherwise each divisor d from 2 up runs in turn through the
//   shared bit-serial divider, until d divides the number or d*d exceeds the number.
// Throughput: one request at a time; req_tready is low until the response is taken.
// Reset: synchronous, active high; clears the sequencer and divider control.
`default_nettype none

module trial_division_primality_test #(
   parameter  int DATA_WIDTH = tdpt_pkg::DEF_DATA_WIDTH,
   localparam int REQ_DATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_DATA_W-1:0]          req_tdata,  // [DATA_WIDTH-1:0] number, rest zero
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tdpt_pkg::RSP_DATA_W-1:0] rsp_tdata  // [0] prime, rest zero
);
   import tdpt_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;     // current trial divisor d
   logic [DATA_WIDTH:0]   sq_ff, sq_in;       // d*d, kept by adding 2d+1 per step
   logic                  prime_ff, prime_in;
   logic                  div_start;
   logic                  bound_over;
   logic [DATA_WIDTH-1:0] req_num;
   div_sts_type           div_sts;

   assign req_num = req_tdata[DATA_WIDTH-1:0];

   // Out of divisors once d*d exceeds the number
   assign bound_over = (sq_ff > {1'b0, num_ff});
   assign div_start  = (state_ff == ST_CHECK) && !bound_over;

   tdpt_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (div_ff),
      .sts      (div_sts)
   );

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               num_in = req_num;
               div_in = DATA_WIDTH'(2);
               sq_in  = (DATA_WIDTH + 1)'(4);
               // Negative, zero and one are never prime: answer at once
               if (req_num[DATA_WIDTH-1] || (req_num <= DATA_WIDTH'(1))) begin
                  prime_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (bound_over) begin
               prime_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (div_sts.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  // advance to d+1: (d+1)^2 = d^2 + 2d + 1
                  div_in   = div_ff + DATA_WIDTH'(1);
                  sq_in    = sq_ff + {div_ff, 1'b1};
                  state_in = ST_CHECK;
               end
            end
         end
         ST_OUT: begin
            // hold the response until it is taken
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      prime_ff <= prime_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {{(RSP_DATA_W - 1){1'b0}}, prime_ff};

endmodule

`default_nettype wire
